[design/pcr_pkg.sv]
`timescale 1ns / 1ps
package pcr_pkg;

  // Field widths of the channels
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned IFX_W      = 31;
  localparam int unsigned STAMP_W    = 64;
  localparam int unsigned PLEN_W     = 16;
  localparam int unsigned DWORD_W    = 32;
  localparam int unsigned BCNT_W     = 3;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned BLEN_W     = 17;

  localparam int unsigned MAX_IFACES_DEF = 16;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_SECTION = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ADD_IF  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_HEADER  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_DATA    = 2'd3;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN = 2'd2;
  localparam logic [STATUS_W-1:0] ST_ZLEN    = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BOOT_TIME = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WALL_TIME = 1'b1;

  // Block constants
  localparam logic [31:0] SHB_TYPE    = 32'h0A0D0D0A;
  localparam logic [31:0] IDB_TYPE    = 32'h00000001;
  localparam logic [31:0] EPB_TYPE    = 32'h00000006;
  localparam logic [31:0] ORDER_MAGIC = 32'h1A2B3C4D;
  localparam logic [31:0] SHB_LEN     = 32'd28;
  localparam logic [31:0] IDB_LEN     = 32'd32;
  localparam logic [31:0] SNAP_LEN    = 32'd65535;
  localparam logic [31:0] TSRESOL_OPT = 32'h00010009;
  localparam logic [31:0] NS_RESOL    = 32'd9;
  localparam logic [BLEN_W-1:0] EPB_BASE = 17'd32;

  // Microcode
  localparam int unsigned PC_W = 6;

  typedef enum logic [4:0] {
    SRC_ZERO,
    SRC_SHB_TYPE,
    SRC_SHB_LEN,
    SRC_MAGIC,
    SRC_ONE,
    SRC_ONES,
    SRC_IDB_TYPE,
    SRC_IDB_LEN,
    SRC_SNAP,
    SRC_OPT,
    SRC_NSRES,
    SRC_EPB_TYPE,
    SRC_CUR_LEN,
    SRC_ID,
    SRC_WALL_HI,
    SRC_WALL_LO,
    SRC_LEN,
    SRC_DATA
  } src_e;

  typedef enum logic [3:0] {
    C_NEXT,     // fall through
    C_JUMP,     // always jump
    C_FULL,     // interface table full
    C_ZLEN,     // zero packet length
    C_SEND,     // search index reached the fill count
    C_MATCH,    // table entry equals the item's interface
    C_DROP,     // dropping a packet
    C_NOOPEN,   // no packet open
    C_NOTLAST   // data word is not the last one
  } cond_e;

  typedef enum logic [3:0] {
    A_NONE,
    A_CLR_I,
    A_INC_I,
    A_ADD_IF,
    A_HDR_INIT,
    A_CALC,
    A_WALL,
    A_SET_DROP,
    A_DROP_LAST,
    A_CLOSE
  } act_e;

  typedef struct packed {
    logic                emit;
    src_e                src;
    logic                eob;
    logic [STATUS_W-1:0] status;
    cond_e               cond;
    act_e                act;
    logic [PC_W-1:0]     target;
  } ctrl_t;

  // Program addresses
  localparam logic [PC_W-1:0] P_IDLE     = PC_W'(0);
  localparam logic [PC_W-1:0] P_SHB      = PC_W'(1);
  localparam logic [PC_W-1:0] P_ADD      = PC_W'(8);
  localparam logic [PC_W-1:0] P_ADD_LOOP = PC_W'(9);
  localparam logic [PC_W-1:0] P_ADD_CMP  = PC_W'(10);
  localparam logic [PC_W-1:0] P_ADD_NEXT = PC_W'(11);
  localparam logic [PC_W-1:0] P_ADD_MISS = PC_W'(12);
  localparam logic [PC_W-1:0] P_ERR_FULL = PC_W'(20);
  localparam logic [PC_W-1:0] P_HDR      = PC_W'(21);
  localparam logic [PC_W-1:0] P_HDR_LOOP = PC_W'(22);
  localparam logic [PC_W-1:0] P_HDR_CMP  = PC_W'(23);
  localparam logic [PC_W-1:0] P_HDR_NEXT = PC_W'(24);
  localparam logic [PC_W-1:0] P_HDR_HIT  = PC_W'(25);
  localparam logic [PC_W-1:0] P_HDR_WALL = PC_W'(26);
  localparam logic [PC_W-1:0] P_HDR_EMIT = PC_W'(27);
  localparam logic [PC_W-1:0] P_ERR_ZLEN = PC_W'(34);
  localparam logic [PC_W-1:0] P_ERR_UNK  = PC_W'(35);
  localparam logic [PC_W-1:0] P_DAT      = PC_W'(36);
  localparam logic [PC_W-1:0] P_DAT_OPEN = PC_W'(37);
  localparam logic [PC_W-1:0] P_DAT_WORD = PC_W'(38);
  localparam logic [PC_W-1:0] P_DAT_TRL  = PC_W'(39);
  localparam logic [PC_W-1:0] P_DAT_DROP = PC_W'(40);

  function automatic ctrl_t mk(input logic emit, input src_e src, input logic eob,
                               input logic [STATUS_W-1:0] st, input cond_e cond,
                               input act_e act, input logic [PC_W-1:0] tgt);
    ctrl_t c;
    c.emit   = emit;
    c.src    = src;
    c.eob    = eob;
    c.status = st;
    c.cond   = cond;
    c.act    = act;
    c.target = tgt;
    return c;
  endfunction

  // Control store: one word per step
  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t c;
    c = mk(1'b0, SRC_ZERO, 1'b0, ST_OK, C_JUMP, A_NONE, P_IDLE);
    unique case (pc)
      // section header block
      PC_W'(1):  c = mk(1'b1, SRC_SHB_TYPE, 1'b0, ST_OK, C_NEXT, A_NONE, P_IDLE);
      PC_W'(2):  c = mk(1'b1, SRC_SHB_LEN,  1'b0, ST_OK, C_NEXT, A_NONE, P_IDLE);
      PC_W'(3):  c = mk(1'b1, SRC_MAGIC,    1'b0, ST_OK, C_NEXT, A_NONE, P_IDLE);
      PC_W'(4):  c = mk(1'b1, SRC_ONE,      1'b0, ST_OK, C_NEXT, A_NONE, P_IDLE);
      PC_W'(5):  c = mk(1'b1, SRC_ONES,     1'b0, ST_OK, C_NEXT, A_NONE, P_IDLE);
      PC_W'(6):  c = mk(1'b1, SRC_ONES,     1'b0, ST_OK, C_NEXT, A_NONE, P_IDLE);
      PC_W'(7):  c = mk(1'b1, SRC_SHB_LEN,  1'b1, ST_OK, C_JUMP, A_NONE, P_IDLE);
      // add interface
      PC_W'(8):  c = mk(1'b0, SRC_ZERO, 1'b0, ST_OK, C_FULL,  A_CLR_I, P_ERR_FULL);
      PC_W'(9):  c = mk(1'b0, SRC_ZERO, 1'b0, ST_OK, C_SEND,  A_NONE,  P_ADD_MISS);
      PC_W'(10): c = mk(1'b0, SRC_ZERO, 1'b0, ST_OK, C_MATCH, A_NONE,  P_IDLE);
      PC_W'(11): c = mk(1'b0, SRC_ZERO, 1'b0, ST_OK, C_JUMP,  A_INC_I, P_ADD_LOOP);
      PC_W'(12): c = mk(1'b1, SRC_IDB_TYPE, 1'b0, ST_OK, C_NEXT, A_ADD_IF, P_IDLE);
      PC_W'(13): c = mk(1'b1, SRC_IDB_LEN,  1'b0, ST_OK, C_NEXT, A_NONE, P_IDLE);
      PC_W'(14): c = mk(1'b1, SRC_ONE,      1'b0, ST_OK, C_NEXT, A_NONE, P_IDLE);
      PC_W'(15): c = mk(1'b1, SRC_SNAP,     1'b0, ST_OK, C_NEXT, A_NONE, P_IDLE);
      PC_W'(16): c = mk(1'b1, SRC_OPT,      1'b0, ST_OK, C_NEXT, A_NONE, P_IDLE);
      PC_W'(17): c = mk(1'b1, SRC_NSRES,    1'b0, ST_OK, C_NEXT, A_NONE, P_IDLE);
      PC_W'(18): c = mk(1'b1, SRC_ZERO,     1'b0, ST_OK, C_NEXT, A_NONE, P_IDLE);
      PC_W'(19): c = mk(1'b1, SRC_IDB_LEN,  1'b1, ST_OK, C_JUMP, A_NONE, P_IDLE);
      PC_W'(20): c = mk(1'b1, SRC_ZERO, 1'b1, ST_FULL, C_JUMP, A_NONE, P_IDLE);
      // packet header
      PC_W'(21): c = mk(1'b0, SRC_ZERO, 1'b0, ST_OK, C_ZLEN,  A_HDR_INIT, P_ERR_ZLEN);
      PC_W'(22): c = mk(1'b0, SRC_ZERO, 1'b0, ST_OK, C_SEND,  A_NONE,  P_ERR_UNK);
      PC_W'(23): c = mk(1'b0, SRC_ZERO, 1'b0, ST_OK, C_MATCH, A_NONE,  P_HDR_HIT);
      PC_W'(24): c = mk(1'b0, SRC_ZERO, 1'b0, ST_OK, C_JUMP,  A_INC_I, P_HDR_LOOP);
      PC_W'(25): c = mk(1'b0, SRC_ZERO, 1'b0, ST_OK, C_NEXT,  A_CALC,  P_IDLE);
      PC_W'(26): c = mk(1'b0, SRC_ZERO, 1'b0, ST_OK, C_NEXT,  A_WALL,  P_IDLE);
      PC_W'(27): c = mk(1'b1, SRC_EPB_TYPE, 1'b0, ST_OK, C_NEXT, A_NONE, P_IDLE);
      PC_W'(28): c = mk(1'b1, SRC_CUR_LEN,  1'b0, ST_OK, C_NEXT, A_NONE, P_IDLE);
      PC_W'(29): c = mk(1'b1, SRC_ID,       1'b0, ST_OK, C_NEXT, A_NONE, P_IDLE);
      PC_W'(30): c = mk(1'b1, SRC_WALL_HI,  1'b0, ST_OK, C_NEXT, A_NONE, P_IDLE);
      PC_W'(31): c = mk(1'b1, SRC_WALL_LO,  1'b0, ST_OK, C_NEXT, A_NONE, P_IDLE);
      PC_W'(32): c = mk(1'b1, SRC_LEN,      1'b0, ST_OK, C_NEXT, A_NONE, P_IDLE);
      PC_W'(33): c = mk(1'b1, SRC_LEN,      1'b0, ST_OK, C_JUMP, A_NONE, P_IDLE);
      PC_W'(34): c = mk(1'b1, SRC_ZERO, 1'b1, ST_ZLEN,    C_JUMP, A_SET_DROP, P_IDLE);
      PC_W'(35): c = mk(1'b1, SRC_ZERO, 1'b1, ST_UNKNOWN, C_JUMP, A_SET_DROP, P_IDLE);
      // packet data word
      PC_W'(36): c = mk(1'b0, SRC_ZERO, 1'b0, ST_OK, C_DROP,   A_NONE, P_DAT_DROP);
      PC_W'(37): c = mk(1'b0, SRC_ZERO, 1'b0, ST_OK, C_NOOPEN, A_NONE, P_IDLE);
      PC_W'(38): c = mk(1'b1, SRC_DATA, 1'b0, ST_OK, C_NOTLAST, A_NONE, P_IDLE);
      PC_W'(39): c = mk(1'b1, SRC_CUR_LEN, 1'b1, ST_OK, C_JUMP, A_CLOSE, P_IDLE);
      PC_W'(40): c = mk(1'b0, SRC_ZERO, 1'b0, ST_OK, C_JUMP, A_DROP_LAST, P_IDLE);
      default:   c = mk(1'b0, SRC_ZERO, 1'b0, ST_OK, C_JUMP, A_NONE, P_IDLE);
    endcase
    return c;
  endfunction

endpackage

[design/pcr_item_if.sv]
`timescale 1ns / 1ps
interface pcr_item_if;
  import pcr_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [KIND_W-1:0]    kind;
  logic [IFX_W-1:0]     iface_index;
  logic [STAMP_W-1:0]   stamp_ns;
  logic [PLEN_W-1:0]    packet_length;
  logic [DWORD_W-1:0]   data_word;
  logic [BCNT_W-1:0]    byte_count;
  logic                 last_word;

  modport source (output valid, kind, iface_index, stamp_ns, packet_length, data_word,
                  byte_count, last_word, input ready);
  modport sink (input valid, kind, iface_index, stamp_ns, packet_length, data_word,
                byte_count, last_word, output ready);
endinterface

[design/pcr_word_if.sv]
`timescale 1ns / 1ps
interface pcr_word_if;
  import pcr_pkg::*;

  logic                valid;
  logic                ready;
  logic [31:0]         word;
  logic                end_of_block;
  logic [STATUS_W-1:0] status;

  modport source (output valid, word, end_of_block, status, input ready);
  modport sink (input valid, word, end_of_block, status, output ready);
endinterface

[design/pcr_cfg_if.sv]
`timescale 1ns / 1ps
interface pcr_cfg_if;
  import pcr_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[design/pcr_ram.sv]
`timescale 1ns / 1ps
module pcr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

[design/pcapng_capture_record_framer_unit.sv]
`timescale 1ns / 1ps
// pcapng capture record framer. Takes items of four kinds (start section, add
// interface, packet header, packet data word) and emits the pcapng stream as
// 32-bit words, one word per cycle on the output channel when it is not stalled.
// A small microcode sequencer runs one step per cycle unless an emitting step
// waits on the output; input is taken only while the sequencer sits in its idle
// step, so one item is in work at a time. Output per item: start section gives
// 7 words, a data word gives its word plus the trailer when last, and dropped or
// stray data give none. Add interface and packet header search the interface
// table one entry at a time through the table RAM's registered read port; add
// interface gives 8 output words on a miss, and a header gives 7 words. Output
// stalls hold the sequencer on its emitting steps. A full table or a bad header
// gives one error word (word 0, end_of_block set, status code). The table needs
// no clearing after reset: only slots below the fill count are compared.
// The user must write boot_time_ns and wall_time_ns through the configuration
// channel only while the block is idle; the block itself does not enforce it.
module pcapng_capture_record_framer_unit #(
  parameter int unsigned MAX_IFACES = pcr_pkg::MAX_IFACES_DEF
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  pcr_cfg_if.sink     cfg_i,
  pcr_item_if.sink    item_i,
  pcr_word_if.source  word_o
);
  import pcr_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_IFACES + 1);
  localparam int unsigned AW    = (MAX_IFACES > 1) ? $clog2(MAX_IFACES) : 1;

  // sequencer
  logic [PC_W-1:0] pc_q, pc_d;
  ctrl_t           cw;
  logic            go;
  logic            cond_true;
  logic            in_acc;
  logic            out_free;
  logic [PC_W-1:0] entry;

  // state
  logic [CNT_W-1:0]  cnt_q;      // interface table fill count
  logic [CNT_W-1:0]  idx_q;      // search index, also the interface id on a hit
  logic [BLEN_W-1:0] cur_len_q;  // open packet's block length, zero when none
  logic              drop_q;

  // latched item
  logic [IFX_W-1:0]   ifx_q;
  logic [STAMP_W-1:0] stamp_q;
  logic [PLEN_W-1:0]  len_q;
  logic [DWORD_W-1:0] data_q;
  logic [BCNT_W-1:0]  bc_q;
  logic               last_q;

  // configuration and time arithmetic
  logic [63:0]  boot_q, wall_q;
  logic [63:0]  diff_q;
  logic         ge_q;
  logic [63:0]  wall_ns_q;
  logic [64:0]  sub_w;
  logic [BLEN_W-1:0] blen;

  // output register
  logic                out_valid_q;
  logic [31:0]         out_word_q;
  logic                out_eob_q;
  logic [STATUS_W-1:0] out_status_q;
  logic [31:0]         word_sel;
  logic [31:0]         data_masked;

  logic [IFX_W-1:0] ram_rdata;
  logic             ram_we;

  assign cw       = ucode(pc_q);
  assign in_acc   = item_i.valid && item_i.ready;
  assign out_free = !out_valid_q || word_o.ready;
  assign go       = (pc_q != P_IDLE) && (!cw.emit || out_free);

  assign item_i.ready = (pc_q == P_IDLE);
  assign cfg_i.ready  = 1'b1;

  assign word_o.valid        = out_valid_q;
  assign word_o.word         = out_word_q;
  assign word_o.end_of_block = out_eob_q;
  assign word_o.status       = out_status_q;

  // entry point of each item kind
  always_comb begin
    unique case (item_i.kind)
      KIND_SECTION: entry = P_SHB;
      KIND_ADD_IF:  entry = P_ADD;
      KIND_HEADER:  entry = P_HDR;
      KIND_DATA:    entry = P_DAT;
      default:      entry = P_IDLE;
    endcase
  end

  always_comb begin
    unique case (cw.cond)
      C_NEXT:    cond_true = 1'b0;
      C_JUMP:    cond_true = 1'b1;
      C_FULL:    cond_true = (cnt_q >= CNT_W'(MAX_IFACES));
      C_ZLEN:    cond_true = (len_q == '0);
      C_SEND:    cond_true = (idx_q >= cnt_q);
      C_MATCH:   cond_true = (ram_rdata == ifx_q);
      C_DROP:    cond_true = drop_q;
      C_NOOPEN:  cond_true = (cur_len_q == '0);
      C_NOTLAST: cond_true = !last_q;
      default:   cond_true = 1'b1;
    endcase
  end

  always_comb begin
    pc_d = pc_q;
    if (pc_q == P_IDLE) begin
      if (in_acc) begin
        pc_d = entry;
      end
    end else if (go) begin
      pc_d = cond_true ? cw.target : pc_q + PC_W'(1);
    end
  end

  // block length: fixed part plus the length rounded up to whole words
  assign blen  = EPB_BASE + ((BLEN_W'(len_q) + BLEN_W'(3)) & ~BLEN_W'(3));
  assign sub_w = {1'b0, stamp_q} - {1'b0, boot_q};

  always_comb begin
    unique case (bc_q)
      3'd0:    data_masked = '0;
      3'd1:    data_masked = {24'd0, data_q[7:0]};
      3'd2:    data_masked = {16'd0, data_q[15:0]};
      3'd3:    data_masked = {8'd0, data_q[23:0]};
      default: data_masked = data_q;  // four bytes and more
    endcase
  end

  always_comb begin
    unique case (cw.src)
      SRC_ZERO:     word_sel = '0;
      SRC_SHB_TYPE: word_sel = SHB_TYPE;
      SRC_SHB_LEN:  word_sel = SHB_LEN;
      SRC_MAGIC:    word_sel = ORDER_MAGIC;
      SRC_ONE:      word_sel = 32'd1;
      SRC_ONES:     word_sel = '1;
      SRC_IDB_TYPE: word_sel = IDB_TYPE;
      SRC_IDB_LEN:  word_sel = IDB_LEN;
      SRC_SNAP:     word_sel = SNAP_LEN;
      SRC_OPT:      word_sel = TSRESOL_OPT;
      SRC_NSRES:    word_sel = NS_RESOL;
      SRC_EPB_TYPE: word_sel = EPB_TYPE;
      SRC_CUR_LEN:  word_sel = {{(32 - BLEN_W){1'b0}}, cur_len_q};
      SRC_ID:       word_sel = {{(32 - CNT_W){1'b0}}, idx_q};
      SRC_WALL_HI:  word_sel = wall_ns_q[63:32];
      SRC_WALL_LO:  word_sel = wall_ns_q[31:0];
      SRC_LEN:      word_sel = {{(32 - PLEN_W){1'b0}}, len_q};
      SRC_DATA:     word_sel = data_masked;
      default:      word_sel = '0;
    endcase
  end

  assign ram_we = go && (cw.act == A_ADD_IF);

  // interface table; the read port follows the search index every cycle
  pcr_ram #(
    .WIDTH (IFX_W),
    .DEPTH (MAX_IFACES)
  ) u_iface_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i (ifx_q),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= P_IDLE;
      cnt_q       <= '0;
      idx_q       <= '0;
      cur_len_q   <= '0;
      drop_q      <= 1'b0;
      out_valid_q <= 1'b0;
      boot_q      <= '0;
      wall_q      <= '0;
    end else begin
      pc_q <= pc_d;
      if (go) begin
        unique case (cw.act)
          A_CLR_I:     idx_q <= '0;
          A_INC_I:     idx_q <= idx_q + CNT_W'(1);
          A_ADD_IF:    cnt_q <= cnt_q + CNT_W'(1);
          A_HDR_INIT: begin
            cur_len_q <= '0;
            idx_q     <= '0;
          end
          A_CALC: begin
            drop_q    <= 1'b0;
            cur_len_q <= blen;
          end
          A_SET_DROP:  drop_q <= 1'b1;
          A_DROP_LAST: begin
            if (last_q) begin
              drop_q <= 1'b0;
            end
          end
          A_CLOSE:     cur_len_q <= '0;
          default: ;
        endcase
      end
      if (go && cw.emit) begin
        out_valid_q <= 1'b1;
      end else if (word_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_i.valid && cfg_i.ready) begin
        unique case (cfg_i.index)
          REG_BOOT_TIME: boot_q <= cfg_i.data;
          REG_WALL_TIME: wall_q <= cfg_i.data;
          default: ;
        endcase
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ifx_q   <= item_i.iface_index;
      stamp_q <= item_i.stamp_ns;
      len_q   <= item_i.packet_length;
      data_q  <= item_i.data_word;
      bc_q    <= item_i.byte_count;
      last_q  <= item_i.last_word;
    end
    if (go && cw.act == A_CALC) begin
      diff_q <= sub_w[63:0];
      ge_q   <= !sub_w[64];
    end
    // stamps before the boot reading clamp to the wall reading
    if (go && cw.act == A_WALL) begin
      wall_ns_q <= ge_q ? (wall_q + diff_q) : wall_q;
    end
    if (go && cw.emit) begin
      out_word_q   <= word_sel;
      out_eob_q    <= cw.eob;
      out_status_q <= cw.status;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_IFACES))
    else $error("interface count beyond table size");

  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= cnt_q)
    else $error("search index past fill count");

  a_len_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_len_q != '0) |-> (cur_len_q[1:0] == 2'b00 && cur_len_q >= BLEN_W'(36)))
    else $error("open block length malformed");

  a_leave_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (pc_q != P_IDLE))
    else $error("accepted item did not start the sequencer");

endmodule
